// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication sampled on clock, held off while reset is high.
`define ASSERT_IMPLY(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication sampled on clock, checked through reset as well.
`define ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// File: design/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_WRITE = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   localparam logic [5:0] WRITE_ACK_BASE = 6'd32;
   localparam logic [5:0] READ_ACK_BASE  = 6'd40;
   localparam logic [2:0] READ_SUB_LAST  = 3'd4;

   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CLS_TICK,
      CLS_CMD,
      CLS_NONE
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      op_type     op;
      logic [7:0] tx_byte;
      logic       ack_value;
      logic       sda_in;
   } entry_type;

   function automatic logic [5:0] phase_total(input op_type op);
      logic [5:0] total;
      case (op)
         OP_START: total = 6'd4;
         OP_STOP:  total = 6'd4;
         OP_WRITE: total = 6'd37;
         OP_READ:  total = 6'd44;
         default:  total = 6'd0;
      endcase
      return total;
   endfunction

endpackage
`default_nettype wire

// File: design/i2cm_front.sv
`default_nettype none
module i2cm_front (
   input  wire logic [2:0]         req_kind,
   input  wire logic [7:0]         req_tx_byte,
   input  wire logic               req_ack_value,
   input  wire logic               req_sda_in,
   output i2cm_pkg::entry_type     entry
);
   import i2cm_pkg::*;

   always_comb begin
      entry.tx_byte   = req_tx_byte;
      entry.ack_value = req_ack_value;
      entry.sda_in    = req_sda_in;
      entry.op        = OP_IDLE;
      case (req_kind)
         KIND_TICK: begin
            entry.cls = CLS_TICK;
         end
         KIND_START: begin
            entry.cls = CLS_CMD;
            entry.op  = OP_START;
         end
         KIND_STOP: begin
            entry.cls = CLS_CMD;
            entry.op  = OP_STOP;
         end
         KIND_WRITE: begin
            entry.cls = CLS_CMD;
            entry.op  = OP_WRITE;
         end
         KIND_READ: begin
            entry.cls = CLS_CMD;
            entry.op  = OP_READ;
         end
         default: begin
            entry.cls = CLS_NONE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: design/i2cm_queue.sv
`default_nettype none
module i2cm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire i2cm_pkg::entry_type push_data,
   output logic                     full,
   input  wire logic                pop,
   output logic                     pop_valid,
   output i2cm_pkg::entry_type      pop_data
);
   import i2cm_pkg::*;

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: design/i2cm_back.sv
`default_nettype none
module i2cm_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire i2cm_pkg::entry_type q_data,
   output logic                    q_pop,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [15:0]        csr_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_scl_level,
   output logic                    rsp_sda_level,
   output logic                    rsp_busy_res,
   output logic                    rsp_done_res,
   output logic [7:0]              rsp_rx_byte,
   output logic                    rsp_ack_seen,
   output logic                    rsp_rejected
);
   import i2cm_pkg::*;

   logic [15:0] ticks_ff;
   op_type      op_ff, op_in;
   logic [5:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [2:0]  sub_ff, sub_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic        ack_send_ff, ack_send_in;
   logic        scl_line_ff, scl_line_in;
   logic        sda_line_ff, sda_line_in;
   logic        ack_ff, ack_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        done_ff, done_in;
   logic        rej_ff, rej_in;
   logic        busy_ff;

   logic        busy;
   logic        do_apply;
   logic [16:0] count_next;
   logic [5:0]  phase_next;
   logic [5:0]  rel;

   assign csr_ready = 1'b1;
   assign q_pop     = q_valid && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = scl_line_ff;
   assign rsp_sda_level = sda_line_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_rx_byte   = rx_ff;
   assign rsp_ack_seen  = ack_ff;
   assign rsp_rejected  = rej_ff;

   always_comb begin
      op_in       = op_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      sub_in      = sub_ff;
      tx_in       = tx_ff;
      rx_in       = rx_ff;
      ack_send_in = ack_send_ff;
      scl_line_in = scl_line_ff;
      sda_line_in = sda_line_ff;
      ack_in      = ack_ff;
      done_in     = 1'b0;
      rej_in      = 1'b0;
      do_apply    = 1'b0;
      rel         = '0;
      busy        = (op_ff != OP_IDLE);
      count_next  = {1'b0, count_ff} + 17'd1;
      phase_next  = phase_ff + 6'd1;

      if (q_pop) begin
         case (q_data.cls)
            CLS_TICK: begin
               if (busy) begin
                  if (count_next >= {1'b0, ticks_ff}) begin
                     count_in = '0;
                     if (phase_next >= phase_total(op_ff)) begin
                        op_in    = OP_IDLE;
                        phase_in = '0;
                        done_in  = 1'b1;
                     end else begin
                        phase_in = phase_next;
                        sub_in   = (sub_ff == READ_SUB_LAST) ? 3'd0 : sub_ff + 3'd1;
                        do_apply = 1'b1;
                     end
                  end else begin
                     count_in = count_next[15:0];
                  end
               end
            end
            CLS_CMD: begin
               if (busy) begin
                  rej_in = 1'b1;
               end else begin
                  op_in    = q_data.op;
                  phase_in = '0;
                  count_in = '0;
                  sub_in   = '0;
                  if (q_data.op == OP_WRITE) begin
                     tx_in = q_data.tx_byte;
                  end
                  if (q_data.op == OP_READ) begin
                     rx_in       = '0;
                     ack_send_in = q_data.ack_value;
                  end
                  do_apply = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (do_apply) begin
         case (op_in)
            OP_START: begin
               case (phase_in[1:0])
                  2'd0:    sda_line_in = 1'b1;
                  2'd1:    scl_line_in = 1'b1;
                  2'd2:    sda_line_in = 1'b0;
                  default: scl_line_in = 1'b0;
               endcase
            end
            OP_STOP: begin
               case (phase_in[1:0])
                  2'd0:    scl_line_in = 1'b0;
                  2'd1:    sda_line_in = 1'b0;
                  2'd2:    scl_line_in = 1'b1;
                  default: sda_line_in = 1'b1;
               endcase
            end
            OP_WRITE: begin
               if (phase_in < WRITE_ACK_BASE) begin
                  case (phase_in[1:0])
                     2'd0: scl_line_in = 1'b0;
                     2'd1: sda_line_in = tx_in[7];
                     2'd2: scl_line_in = 1'b1;
                     default: begin
                        scl_line_in = 1'b0;
                        tx_in       = {tx_in[6:0], 1'b0};
                     end
                  endcase
               end else begin
                  rel = phase_in - WRITE_ACK_BASE;
                  case (rel[2:0])
                     3'd0:    sda_line_in = 1'b1;
                     3'd1:    scl_line_in = 1'b0;
                     3'd2:    scl_line_in = 1'b1;
                     3'd3:    ack_in      = q_data.sda_in;
                     default: scl_line_in = 1'b0;
                  endcase
               end
            end
            OP_READ: begin
               if (phase_in < READ_ACK_BASE) begin
                  case (sub_in)
                     3'd0:    sda_line_in = 1'b1;
                     3'd1:    scl_line_in = 1'b0;
                     3'd2:    scl_line_in = 1'b1;
                     3'd3:    rx_in       = {rx_in[6:0], q_data.sda_in};
                     default: scl_line_in = 1'b0;
                  endcase
               end else begin
                  rel = phase_in - READ_ACK_BASE;
                  case (rel[1:0])
                     2'd0:    scl_line_in = 1'b0;
                     2'd1:    sda_line_in = ack_send_in;
                     2'd2:    scl_line_in = 1'b1;
                     default: scl_line_in = 1'b0;
                  endcase
               end
            end
            default: begin
            end
         endcase
      end

      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= 16'd1;
         op_ff        <= OP_IDLE;
         phase_ff     <= '0;
         count_ff     <= '0;
         sub_ff       <= '0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         ack_send_ff  <= 1'b0;
         scl_line_ff  <= 1'b1;
         sda_line_ff  <= 1'b1;
         ack_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            ticks_ff <= csr_data;
         end
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sub_ff       <= sub_in;
         tx_ff        <= tx_in;
         rx_ff        <= rx_in;
         ack_send_ff  <= ack_send_in;
         scl_line_ff  <= scl_line_in;
         sda_line_ff  <= sda_line_in;
         ack_ff       <= ack_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         done_ff <= done_in;
         rej_ff  <= rej_in;
         busy_ff <= (op_in != OP_IDLE);
      end
   end

endmodule
`default_nettype wire

// File: design/i2c_master_byte_engine.sv
// I2C master line sequencer.
// req_* carries one beat per item: a tick with the sampled SDA level, or a
// start, stop, write byte or read byte command. A beat is taken when
// req_valid is high and req_stall is low. Every beat returns exactly one
// rsp_* beat with the line levels, busy/done flags, the read shift register,
// the last write acknowledge and a rejected flag for a command sent while busy.
// csr_* writes phase_ticks (ticks per line phase); csr_ready is always high.
// Write it only while no command runs and no beat is in flight.
// A request beat is held in the queue, then its response is registered; one beat per
// cycle is sustained while rsp_stall is low, with the line sequencer behind a 4-entry queue.
// When rsp_stall is held the response holds; the queue keeps taking beats
// until its 4 entries fill, then req_stall rises.
// Reset is synchronous: lines released high, idle, phase_ticks = 1, queue
// and response register empty.
`default_nettype none
module i2c_master_byte_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        req_ack_value,
   input  wire logic        req_sda_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_level,
   output logic             rsp_sda_level,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_rx_byte,
   output logic             rsp_ack_seen,
   output logic             rsp_rejected,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   import i2cm_pkg::*;

   entry_type front_entry;
   entry_type q_data;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;

   assign req_stall = q_full;

   i2cm_front u_front (
      .req_kind      (req_kind),
      .req_tx_byte   (req_tx_byte),
      .req_ack_value (req_ack_value),
      .req_sda_in    (req_sda_in),
      .entry         (front_entry)
   );

   i2cm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_data (front_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   i2cm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl_level (rsp_scl_level),
      .rsp_sda_level (rsp_sda_level),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_ack_seen  (rsp_ack_seen),
      .rsp_rejected  (rsp_rejected)
   );

endmodule
`default_nettype wire

// File: design/i2cm_checker.sv
`default_nettype none
`include "assert_macros.svh"
module i2cm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_busy_res,
   input wire logic        rsp_done_res,
   input wire logic        rsp_rejected,
   input wire logic [7:0]  rsp_rx_byte,
   input wire logic        rsp_scl_level,
   input wire logic        rsp_sda_level
);

   logic       rsp_beat;
   logic [9:0] rsp_lines;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign rsp_lines = {rsp_rx_byte, rsp_scl_level, rsp_sda_level};

   `ASSERT_IMPLY(a_rsp_hold, rsp_valid && rsp_stall, ##1 (rsp_valid && $stable(rsp_lines)))
   `ASSERT_IMPLY(a_done_idle, rsp_beat && rsp_done_res, !rsp_busy_res)
   `ASSERT_IMPLY(a_reject_busy, rsp_beat && rsp_rejected, rsp_busy_res && !rsp_done_res)
   `ASSERT_NEXT(a_reset_empty, reset, !rsp_valid && !req_stall)

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (.*);
`default_nettype wire
